// ===== hdl/i2cms_pkg.sv =====
// Shared types and constants for the I2C master status sequencer.
// No dependencies; imported by the sequencer, the scoreboard package and the bench.
package i2cms_pkg;

    localparam int BUF_DEPTH = 16;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    localparam logic [4:0] BUF_DEPTH_W = 5'(BUF_DEPTH);

    typedef enum logic [2:0] {
        OP_LOAD     = 3'd0,
        OP_START_WR = 3'd1,
        OP_START_RD = 3'd2,
        OP_EVENT    = 3'd3,
        OP_READ     = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } mode_t;

    // Controller status codes
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RSTART       = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

endpackage

// ===== hdl/i2cms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/i2c_master_status_sequencer.sv =====
// I2C master status-code sequencer: start/event/buffer opcodes to control actions.
// Depends on i2cms_pkg and i2cms_ram (payload byte buffer).
// Each beat passes the input register, then the result register; out_stall can hold it in the input register.
// Throughput: one beat per cycle while out_stall is low; the buffer read for a beat is issued as it is accepted.
// Reset clears mode, address, length and position; buffer contents are undefined
// until written.
module i2c_master_status_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] opcode,
    input  logic [7:0] slave_byte,
    input  logic [4:0] length,
    input  logic [3:0] index,
    input  logic [7:0] tx_byte,
    input  logic [7:0] bus_status,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       data_write_valid,
    output logic [7:0] data_value,
    output logic       set_start,
    output logic       set_stop,
    output logic       set_ack,
    output logic       clear_start,
    output logic       clear_ack,
    output logic       clear_interrupt,
    output logic       done_res,
    output logic [4:0] byte_count,
    output logic [7:0] read_byte
);

    import i2cms_pkg::*;

    // Input stage
    logic       a_valid_reg, a_valid_next;
    logic [2:0] op_reg;
    logic [7:0] sl_reg;
    logic [4:0] len_reg;
    logic [3:0] idx_reg;
    logic [7:0] txb_reg;
    logic [7:0] st_reg;
    logic [7:0] rx_reg;

    // Sequencer state
    mode_t      mode_reg, mode_next;
    logic [7:0] slave_reg, slave_next;
    logic [4:0] length_reg, length_next;
    logic [4:0] pos_reg, pos_next;

    // Result stage
    logic       out_valid_reg, out_valid_next;
    logic       dwv_reg, dwv_next;
    logic [7:0] dval_reg, dval_next;
    logic       ssta_reg, ssta_next;
    logic       sack_reg, sack_next;
    logic       csta_reg, csta_next;
    logic       cack_reg, cack_next;
    logic       csi_reg, csi_next;
    logic       done_reg, done_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [7:0] rd_reg, rd_next;

    // Buffer access
    logic              buf_we;
    logic [BUF_AW-1:0] buf_waddr;
    logic [7:0]        buf_wdata;
    logic [BUF_AW-1:0] buf_raddr;
    logic [7:0]        buf_q;
    logic [7:0]        buf_rdata;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_data_reg;

    logic       out_ready;
    logic       fire;
    logic       accept;
    logic [4:0] pos_dec;
    logic       tx_more;
    logic       rx_more;
    logic [4:0] rd_pos;

    assign out_ready = !out_valid_reg || !out_stall;
    assign fire      = a_valid_reg && out_ready;
    assign in_stall  = a_valid_reg && !out_ready;
    assign accept    = in_valid && !in_stall;

    assign pos_dec = (st_reg == ST_MT_DATA_NACK && pos_reg != 5'd0) ? pos_reg - 5'd1 : pos_reg;
    assign tx_more = (pos_dec < length_reg) && (pos_dec < BUF_DEPTH_W);
    assign rx_more = (pos_reg < length_reg) && (pos_reg < BUF_DEPTH_W);

    // Read address for the beat being accepted, from the position it will see
    assign rd_pos = (bus_status == ST_MT_DATA_NACK && pos_next != 5'd0) ?
                    pos_next - 5'd1 : pos_next;
    assign buf_raddr = (opcode == OP_READ) ? index[BUF_AW-1:0] : rd_pos[BUF_AW-1:0];

    assign buf_rdata = fwd_hit_reg ? fwd_data_reg : buf_q;

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .re    (accept),
        .raddr (buf_raddr),
        .rdata (buf_q)
    );

    always_comb
    begin
        mode_next   = mode_reg;
        slave_next  = slave_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        dwv_next    = 1'b0;
        dval_next   = 8'h00;
        ssta_next   = 1'b0;
        sack_next   = 1'b0;
        csta_next   = 1'b0;
        cack_next   = 1'b0;
        csi_next    = 1'b0;
        done_next   = 1'b0;
        rd_next     = 8'h00;
        buf_we      = 1'b0;
        buf_waddr   = idx_reg[BUF_AW-1:0];
        buf_wdata   = txb_reg;

        if (fire)
        begin
            unique case (op_reg)
                OP_LOAD:
                begin
                    buf_we = ({1'b0, idx_reg} < BUF_DEPTH_W);
                end
                OP_START_WR, OP_START_RD:
                begin
                    if (mode_reg == MODE_IDLE)
                    begin
                        mode_next   = (op_reg == OP_START_WR) ? MODE_TX : MODE_RX;
                        slave_next  = sl_reg;
                        length_next = (len_reg > BUF_DEPTH_W) ? BUF_DEPTH_W : len_reg;
                        pos_next    = 5'd0;
                        cack_next   = 1'b1;
                        csi_next    = 1'b1;
                        ssta_next   = 1'b1;
                    end
                end
                OP_EVENT:
                begin
                    csi_next = 1'b1;
                    unique case (mode_reg)
                        MODE_TX:
                        begin
                            unique case (st_reg)
                                ST_MT_SLA_NACK, ST_ARB_LOST:
                                begin
                                    cack_next = 1'b1;
                                    ssta_next = 1'b1;
                                end
                                ST_START, ST_RSTART:
                                begin
                                    dwv_next  = 1'b1;
                                    dval_next = {slave_reg[7:1], 1'b0};
                                    cack_next = 1'b1;
                                    csta_next = 1'b1;
                                end
                                ST_MT_DATA_NACK, ST_MT_SLA_ACK, ST_MT_DATA_ACK:
                                begin
                                    if (tx_more)
                                    begin
                                        dwv_next  = 1'b1;
                                        dval_next = buf_rdata;
                                        pos_next  = pos_dec + 5'd1;
                                        csta_next = 1'b1;
                                        sack_next = 1'b1;
                                    end
                                    else
                                    begin
                                        pos_next  = pos_dec;
                                        csta_next = 1'b1;
                                        cack_next = 1'b1;
                                        done_next = 1'b1;
                                        mode_next = MODE_IDLE;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        MODE_RX:
                        begin
                            unique case (st_reg)
                                ST_ARB_LOST, ST_MR_SLA_NACK:
                                begin
                                    cack_next = 1'b1;
                                    ssta_next = 1'b1;
                                end
                                ST_START, ST_RSTART:
                                begin
                                    dwv_next  = 1'b1;
                                    dval_next = {slave_reg[7:1], 1'b1};
                                    cack_next = 1'b1;
                                    csta_next = 1'b1;
                                end
                                ST_MR_SLA_ACK:
                                begin
                                    csta_next = 1'b1;
                                    sack_next = 1'b1;
                                end
                                ST_MR_DATA_ACK:
                                begin
                                    if (rx_more)
                                    begin
                                        buf_we    = 1'b1;
                                        buf_waddr = pos_reg[BUF_AW-1:0];
                                        buf_wdata = rx_reg;
                                        pos_next  = pos_reg + 5'd1;
                                        csta_next = 1'b1;
                                        sack_next = 1'b1;
                                    end
                                    else
                                    begin
                                        csta_next = 1'b1;
                                        cack_next = 1'b1;
                                        done_next = 1'b1;
                                        mode_next = MODE_IDLE;
                                    end
                                end
                                ST_MR_DATA_NACK:
                                begin
                                    csta_next = 1'b1;
                                    cack_next = 1'b1;
                                    done_next = 1'b1;
                                    mode_next = MODE_IDLE;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_READ:
                begin
                    if ({1'b0, idx_reg} < BUF_DEPTH_W)
                    begin
                        rd_next = buf_rdata;
                    end
                end
                default:
                begin
                end
            endcase
        end

        cnt_next = pos_next;
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (fire)
        begin
            a_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            slave_reg     <= 8'h00;
            length_reg    <= 5'd0;
            pos_reg       <= 5'd0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            slave_reg     <= slave_next;
            length_reg    <= length_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= opcode;
            sl_reg       <= slave_byte;
            len_reg      <= length;
            idx_reg      <= index;
            txb_reg      <= tx_byte;
            st_reg       <= bus_status;
            rx_reg       <= rx_byte;
            fwd_hit_reg  <= buf_we && (buf_waddr == buf_raddr);
            fwd_data_reg <= buf_wdata;
        end
        if (fire)
        begin
            dwv_reg  <= dwv_next;
            dval_reg <= dval_next;
            ssta_reg <= ssta_next;
            sack_reg <= sack_next;
            csta_reg <= csta_next;
            cack_reg <= cack_next;
            csi_reg  <= csi_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rd_reg   <= rd_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign data_write_valid = dwv_reg;
    assign data_value       = dval_reg;
    assign set_start        = ssta_reg;
    assign set_stop         = 1'b0;
    assign set_ack          = sack_reg;
    assign clear_start      = csta_reg;
    assign clear_ack        = cack_reg;
    assign clear_interrupt  = csi_reg;
    assign done_res         = done_reg;
    assign byte_count       = cnt_reg;
    assign read_byte        = rd_reg;

endmodule

// ===== verif/i2cms_scoreboard_pkg.sv =====
// Beat and action types plus the scoreboard that predicts and checks the sequencer.
// Depends on i2cms_pkg for opcodes, modes, status codes and buffer depth.
package i2cms_scoreboard_pkg;

    import i2cms_pkg::*;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] slave_byte;
        logic [4:0] length;
        logic [3:0] index;
        logic [7:0] tx_byte;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
    } beat_t;

    typedef struct packed {
        logic       data_write_valid;
        logic [7:0] data_value;
        logic       set_start;
        logic       set_stop;
        logic       set_ack;
        logic       clear_start;
        logic       clear_ack;
        logic       clear_interrupt;
        logic       done_res;
        logic [4:0] byte_count;
        logic [7:0] read_byte;
    } actions_t;

    class i2cms_scoreboard;

        mode_t      mode = MODE_IDLE;
        logic [7:0] addr_byte = '0;
        logic [4:0] xfer_len = '0;
        logic [4:0] xfer_pos = '0;
        logic [7:0] payload [BUF_DEPTH];

        actions_t   expected_actions [$];
        actions_t   act;
        int         beats_in;
        int         results_checked;
        int         transfers_done;
        int         errors;

        function bit busy();
            return mode != MODE_IDLE;
        endfunction

        function int pending();
            return expected_actions.size();
        endfunction

        function void send_byte(logic [7:0] v);
            act.data_write_valid = 1'b1;
            act.data_value       = v;
        endfunction

        function void wrap_up();
            act.clear_start = 1'b1;
            act.clear_ack   = 1'b1;
            act.done_res    = 1'b1;
            mode            = MODE_IDLE;
            transfers_done++;
        endfunction

        function void tx_status(logic [7:0] st);
            case (st)
                ST_MT_SLA_NACK, ST_ARB_LOST:
                begin
                    act.clear_ack = 1'b1;
                    act.set_start = 1'b1;
                end
                ST_START, ST_RSTART:
                begin
                    send_byte(addr_byte & 8'hFE);
                    act.clear_ack   = 1'b1;
                    act.clear_start = 1'b1;
                end
                ST_MT_DATA_NACK, ST_MT_SLA_ACK, ST_MT_DATA_ACK:
                begin
                    // NACK backs up one byte, never below zero
                    if (st == ST_MT_DATA_NACK && xfer_pos > 0)
                        xfer_pos--;
                    if (xfer_pos < xfer_len && xfer_pos < BUF_DEPTH_W)
                    begin
                        send_byte(payload[xfer_pos]);
                        xfer_pos++;
                        act.clear_start = 1'b1;
                        act.set_ack     = 1'b1;
                    end
                    else
                        wrap_up();
                end
                default: ;
            endcase
        endfunction

        function void rx_status(logic [7:0] st, logic [7:0] rx);
            case (st)
                ST_ARB_LOST, ST_MR_SLA_NACK:
                begin
                    act.clear_ack = 1'b1;
                    act.set_start = 1'b1;
                end
                ST_START, ST_RSTART:
                begin
                    send_byte(addr_byte | 8'h01);
                    act.clear_ack   = 1'b1;
                    act.clear_start = 1'b1;
                end
                ST_MR_SLA_ACK:
                begin
                    act.clear_start = 1'b1;
                    act.set_ack     = 1'b1;
                end
                ST_MR_DATA_ACK:
                begin
                    if (xfer_pos < xfer_len && xfer_pos < BUF_DEPTH_W)
                    begin
                        payload[xfer_pos] = rx;
                        xfer_pos++;
                        act.clear_start = 1'b1;
                        act.set_ack     = 1'b1;
                    end
                    else
                        wrap_up();
                end
                ST_MR_DATA_NACK:
                    wrap_up();
                default: ;
            endcase
        endfunction

        // Called once per accepted input beat; queues the predicted actions.
        function void note_beat(beat_t b);
            act = '0;
            case (b.opcode)
                OP_LOAD:
                    if (b.index < BUF_DEPTH)
                        payload[b.index] = b.tx_byte;
                OP_START_WR, OP_START_RD:
                    if (mode == MODE_IDLE)
                    begin
                        mode      = (b.opcode == OP_START_WR) ? MODE_TX : MODE_RX;
                        addr_byte = b.slave_byte;
                        xfer_len  = (b.length > BUF_DEPTH_W) ? BUF_DEPTH_W : b.length;
                        xfer_pos  = '0;
                        act.clear_ack       = 1'b1;
                        act.clear_interrupt = 1'b1;
                        act.set_start       = 1'b1;
                    end
                OP_EVENT:
                begin
                    if (mode == MODE_TX)
                        tx_status(b.bus_status);
                    else if (mode == MODE_RX)
                        rx_status(b.bus_status, b.rx_byte);
                    act.clear_interrupt = 1'b1;
                end
                OP_READ:
                    if (b.index < BUF_DEPTH)
                        act.read_byte = payload[b.index];
                default: ;
            endcase
            act.byte_count = xfer_pos;
            expected_actions.push_back(act);
            beats_in++;
        endfunction

        function void cmp_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                if (errors <= 50)
                    $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        endfunction

        function void check_actions(actions_t got);
            actions_t want;
            if (expected_actions.size() == 0)
            begin
                errors++;
                $error("result beat with nothing expected");
                return;
            end
            want = expected_actions.pop_front();
            results_checked++;
            cmp_field("data_write_valid", want.data_write_valid, got.data_write_valid);
            cmp_field("data_value", want.data_value, got.data_value);
            cmp_field("set_start", want.set_start, got.set_start);
            cmp_field("set_stop", want.set_stop, got.set_stop);
            cmp_field("set_ack", want.set_ack, got.set_ack);
            cmp_field("clear_start", want.clear_start, got.clear_start);
            cmp_field("clear_ack", want.clear_ack, got.clear_ack);
            cmp_field("clear_interrupt", want.clear_interrupt, got.clear_interrupt);
            cmp_field("done_res", want.done_res, got.done_res);
            cmp_field("byte_count", want.byte_count, got.byte_count);
            cmp_field("read_byte", want.read_byte, got.read_byte);
        endfunction

    endclass

endpackage

// ===== verif/i2c_master_status_sequencer_tb.sv =====
// Self-checking bench for i2c_master_status_sequencer: directed corner beats, then
// random bus transactions with bursty input, patterned output stall and one long hold-off.
// Depends on i2cms_pkg, i2cms_scoreboard_pkg and the sequencer RTL.
module i2c_master_status_sequencer_tb;

    import i2cms_pkg::*;
    import i2cms_scoreboard_pkg::*;

    localparam int RANDOM_BEATS = 1550;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] opcode;
    logic [7:0] slave_byte;
    logic [4:0] length;
    logic [3:0] index;
    logic [7:0] tx_byte;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic       data_write_valid;
    logic [7:0] data_value;
    logic       set_start;
    logic       set_stop;
    logic       set_ack;
    logic       clear_start;
    logic       clear_ack;
    logic       clear_interrupt;
    logic       done_res;
    logic [4:0] byte_count;
    logic [7:0] read_byte;

    i2cms_scoreboard sb = new();
    int burst_left;

    i2c_master_status_sequencer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .slave_byte       (slave_byte),
        .length           (length),
        .index            (index),
        .tx_byte          (tx_byte),
        .bus_status       (bus_status),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .data_write_valid (data_write_valid),
        .data_value       (data_value),
        .set_start        (set_start),
        .set_stop         (set_stop),
        .set_ack          (set_ack),
        .clear_start      (clear_start),
        .clear_ack        (clear_ack),
        .clear_interrupt  (clear_interrupt),
        .done_res         (done_res),
        .byte_count       (byte_count),
        .read_byte        (read_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic beat_t rand_beat(logic [2:0] op);
        beat_t b;
        b.opcode     = op;
        b.slave_byte = 8'($urandom);
        b.length     = 5'($urandom);
        b.index      = 4'($urandom);
        b.tx_byte    = 8'($urandom);
        b.bus_status = 8'($urandom);
        b.rx_byte    = 8'($urandom);
        return b;
    endfunction

    function automatic beat_t event_beat(logic [7:0] st);
        beat_t b;
        b = rand_beat(OP_EVENT);
        b.bus_status = st;
        return b;
    endfunction

    // Mostly the codes that move the current transfer forward, some detours and noise.
    function automatic logic [7:0] pick_status();
        int r;
        r = $urandom_range(0, 99);
        if (sb.mode == MODE_TX)
        begin
            if (r < 50) return ST_MT_DATA_ACK;
            if (r < 60) return ST_MT_SLA_ACK;
            if (r < 66) return ST_START;
            if (r < 70) return ST_RSTART;
            if (r < 82) return ST_MT_DATA_NACK;
            if (r < 86) return ST_MT_SLA_NACK;
            if (r < 90) return ST_ARB_LOST;
        end
        else
        begin
            if (r < 50) return ST_MR_DATA_ACK;
            if (r < 58) return ST_MR_DATA_NACK;
            if (r < 68) return ST_MR_SLA_ACK;
            if (r < 74) return ST_START;
            if (r < 78) return ST_RSTART;
            if (r < 84) return ST_MR_SLA_NACK;
            if (r < 90) return ST_ARB_LOST;
        end
        return 8'($urandom);
    endfunction

    task automatic send_beat(beat_t b);
        in_valid   <= 1'b1;
        opcode     <= b.opcode;
        slave_byte <= b.slave_byte;
        length     <= b.length;
        index      <= b.index;
        tx_byte    <= b.tx_byte;
        bus_status <= b.bus_status;
        rx_byte    <= b.rx_byte;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_beat(b);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic run_directed();
        beat_t b;
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            b = rand_beat(OP_LOAD);
            b.index = 4'(i);
            if (i == 0)
                b.tx_byte = 8'h00;
            else if (i == BUF_DEPTH - 1)
                b.tx_byte = 8'hFF;
            send_beat(b);
        end
        b = rand_beat(OP_READ);
        b.index = 4'(BUF_DEPTH - 1);
        send_beat(b);
        // status while idle, then an undefined opcode
        send_beat(event_beat(ST_MT_DATA_ACK));
        send_beat(rand_beat(3'd7));
        // length above buffer depth saturates
        b = rand_beat(OP_START_WR);
        b.slave_byte = 8'hFF;
        b.length     = 5'h1F;
        send_beat(b);
        // start while busy is dropped
        send_beat(rand_beat(OP_START_RD));
        send_beat(event_beat(ST_START));
        // data NACK with nothing sent yet does not back up below position zero
        send_beat(event_beat(ST_MT_DATA_NACK));
        send_beat(event_beat(8'h77));
        send_beat(event_beat(ST_MT_DATA_ACK));
    endtask

    task automatic run_random();
        beat_t b;
        int    counted;
        int    r;
        counted = 0;
        while (counted < RANDOM_BEATS)
        begin
            r = $urandom_range(0, 19);
            if (!sb.busy())
            begin
                if (r < 12)
                begin
                    b = rand_beat((r < 6) ? OP_START_WR : OP_START_RD);
                    b.length = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                           : 5'($urandom_range(0, 5));
                end
                else if (r < 15)
                    b = rand_beat(OP_LOAD);
                else if (r < 18)
                    b = rand_beat(OP_READ);
                else
                    b = rand_beat(3'($urandom));
            end
            else
            begin
                if (r == 0)
                    b = rand_beat(3'($urandom));
                else if (r == 1)
                    b = rand_beat(($urandom_range(0, 1) == 0) ? OP_LOAD : OP_READ);
                else if (r == 2)
                    b = rand_beat(($urandom_range(0, 1) == 0) ? OP_START_WR : OP_START_RD);
                else
                    b = event_beat(pick_status());
            end
            counted++;
            send_beat(b);
        end
        // bring any open transfer to an end
        while (sb.busy())
            send_beat(event_beat((sb.mode == MODE_TX) ? ST_MT_DATA_ACK : ST_MR_DATA_NACK));
    endtask

    initial
    begin
        int guard;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = '0;
        slave_byte = '0;
        length     = '0;
        index      = '0;
        tx_byte    = '0;
        bus_status = '0;
        rx_byte    = '0;
        burst_left = 0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20)
            @(posedge clk);
        if (sb.pending() != 0)
            $error("%0d expected results never arrived", sb.pending());
        $display("Checked %0d result beats for %0d input beats; %0d transfers ran to done.",
                 sb.results_checked, sb.beats_in, sb.transfers_done);
        $display("Covered buffer load/readout, write and read transfers, NACK retries and noise.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver: stall in changing styles, plus one long hold-off mid-run.
    initial
    begin
        int hold_left;
        int phase_left;
        int style;
        bit held;
        logic stall;
        hold_left  = 0;
        phase_left = 0;
        style      = 0;
        held       = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sb.beats_in >= 700)
            begin
                held      = 1'b1;
                hold_left = 250;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall = 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    phase_left = $urandom_range(32, 200);
                end
                phase_left--;
                case (style)
                    0: stall = 1'b0;
                    1: stall = ($urandom_range(0, 3) == 0);
                    2: stall = ($urandom_range(0, 9) < 6);
                    default: stall = ~out_stall;
                endcase
            end
            out_stall <= stall;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_actions('{data_write_valid, data_value, set_start, set_stop, set_ack,
                               clear_start, clear_ack, clear_interrupt, done_res,
                               byte_count, read_byte});
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/i2cms_pkg.sv
hdl/i2cms_ram.sv
hdl/i2c_master_status_sequencer.sv
verif/i2cms_scoreboard_pkg.sv
verif/i2c_master_status_sequencer_tb.sv
